>>> sv/http_header_length_framer_unit_macros.svh
// assertion macros for the http header length framer checker
// no dependencies; taken in by the checker file
`ifndef HTTP_HEADER_LENGTH_FRAMER_UNIT_MACROS_SVH
`define HTTP_HEADER_LENGTH_FRAMER_UNIT_MACROS_SVH

// same-cycle implication, clocked on clk, off during reset
`define HHLF_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, clocked on clk, off during reset
`define HHLF_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> sv/hhlf_pkg.sv
// types, constants and per-byte header scanning functions for the framer
// no dependencies; used by the top level and the checker
package hhlf_pkg;

	localparam int IN_DATA_W  = 8;
	localparam int LEN_W      = 31;
	localparam int OUT_DATA_W = 40;

	localparam logic [LEN_W-1:0] LEN_MAX = {LEN_W{1'b1}};

	// output word layout, lowest bit first
	localparam int O_HDR_END = 0;
	localparam int O_LEN_LO  = 1;
	localparam int O_LEN_HI  = 31;
	localparam int O_KNOWN   = 32;
	localparam int O_BLESS   = 33;
	localparam int O_CLOSED  = 34;

	// item kinds on the input tuser
	localparam logic OP_DATA  = 1'b0;
	localparam logic OP_CLOSE = 1'b1;

	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_UP_A  = 8'h41;
	localparam logic [7:0] CH_UP_Z  = 8'h5A;

	localparam logic [3:0] NAME_LEN = 4'd14;
	localparam logic [3:0] NAME_SAT = 4'd15;
	localparam logic [3:0] PFX_SAT  = 4'd13;

	// "content-length"
	localparam logic [7:0] NAME_TEXT [14] = '{
		8'h63, 8'h6F, 8'h6E, 8'h74, 8'h65, 8'h6E, 8'h74,
		8'h2D, 8'h6C, 8'h65, 8'h6E, 8'h67, 8'h74, 8'h68
	};

	// "HTTP/1.1 401"; the caller swaps the minor digit for HTTP/1.0
	localparam logic [7:0] HTTP_TEXT [12] = '{
		8'h48, 8'h54, 8'h54, 8'h50, 8'h2F, 8'h31,
		8'h2E, 8'h31, 8'h20, 8'h34, 8'h30, 8'h31
	};

	typedef enum logic [1:0] {
		PH_SKIP,
		PH_DIGITS,
		PH_DONE
	} val_phase_t;

	// per-line scan state, plus the sticky bodyless flag
	typedef struct packed {
		logic             line_empty;
		logic [3:0]       pfx_pos;
		logic [2:0]       pfx_alive;
		logic [3:0]       name_pos;
		logic             name_alive;
		logic             colon;
		val_phase_t       phase;
		logic             neg;
		logic [LEN_W-1:0] acc;
		logic             bodyless;
	} hdr_st_t;

	function automatic logic is_ws(input logic [7:0] c);
		return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
	endfunction

	function automatic logic [3:0] pfx_len(input logic [1:0] idx);
		return (idx == 2'd0) ? 4'd3 : 4'd12;
	endfunction

	// expected prefix character; 0 = GET, 1 = HTTP/1.1 401, 2 = HTTP/1.0 401
	function automatic logic [7:0] pfx_char(input logic [1:0] idx, input logic [3:0] p);
		logic [7:0] ch;
		ch = 8'h00;
		if (idx == 2'd0) begin
			case (p)
				4'd0:    ch = 8'h47;
				4'd1:    ch = 8'h45;
				4'd2:    ch = 8'h54;
				default: ch = 8'h00;
			endcase
		end else if (p < 4'd12) begin
			ch = HTTP_TEXT[p];
			if (p == 4'd7 && idx == 2'd2)
				ch = CH_ZERO;
		end
		return ch;
	endfunction

	// line start: all scan state back to idle, bodyless kept
	function automatic hdr_st_t line_restart(input hdr_st_t st);
		hdr_st_t nx;
		nx            = st;
		nx.line_empty = 1'b1;
		nx.pfx_pos    = 4'd0;
		nx.pfx_alive  = 3'b111;
		nx.name_pos   = 4'd0;
		nx.name_alive = 1'b1;
		nx.colon      = 1'b0;
		nx.phase      = PH_SKIP;
		nx.neg        = 1'b0;
		nx.acc        = '0;
		return nx;
	endfunction

	// one ordinary line byte through prefix match, name match and value decode
	function automatic hdr_st_t content_byte(input hdr_st_t st, input logic first_line,
		input logic [7:0] c);
		hdr_st_t     nx;
		logic [7:0]  lc;
		logic [3:0]  dig;
		logic        is_dig;
		logic [34:0] prod;
		nx            = st;
		nx.line_empty = 1'b0;
		dig           = c[3:0];
		is_dig        = (c >= CH_ZERO) && (c <= CH_NINE);
		lc            = ((c >= CH_UP_A) && (c <= CH_UP_Z)) ? (c + 8'd32) : c;
		prod          = {1'b0, st.acc, 3'b000} + {3'b000, st.acc, 1'b0} + {31'd0, dig};

		// bodyless prefix test on the first line
		if (first_line) begin
			for (int i = 0; i < 3; i++) begin
				if (st.pfx_alive[i]) begin
					if (st.pfx_pos < pfx_len(2'(i))) begin
						if (c != pfx_char(2'(i), st.pfx_pos))
							nx.pfx_alive[i] = 1'b0;
					end else begin
						if (is_ws(c))
							nx.bodyless = 1'b1;
						nx.pfx_alive[i] = 1'b0;
					end
				end
			end
			nx.pfx_pos = (st.pfx_pos < PFX_SAT) ? (st.pfx_pos + 4'd1) : PFX_SAT;
		end

		// header name up to the first colon, then the value
		if (!st.colon) begin
			if (c == CH_COLON) begin
				nx.colon      = 1'b1;
				nx.name_alive = st.name_alive && (st.name_pos == NAME_LEN);
			end else begin
				if (!((st.name_pos < NAME_LEN) && (lc == NAME_TEXT[st.name_pos])))
					nx.name_alive = 1'b0;
				nx.name_pos = (st.name_pos < NAME_SAT) ? (st.name_pos + 4'd1) : NAME_SAT;
			end
		end else begin
			case (st.phase)
				PH_SKIP: begin
					if (is_ws(c)) begin
						nx.phase = PH_SKIP;
					end else if (c == CH_PLUS) begin
						nx.phase = PH_DIGITS;
					end else if (c == CH_MINUS) begin
						nx.phase = PH_DIGITS;
						nx.neg   = 1'b1;
					end else if (is_dig) begin
						nx.phase = PH_DIGITS;
						nx.acc   = {27'd0, dig};
					end else begin
						nx.phase = PH_DONE;
					end
				end
				PH_DIGITS: begin
					if (is_dig)
						nx.acc = (prod > {4'd0, LEN_MAX}) ? LEN_MAX : prod[LEN_W-1:0];
					else
						nx.phase = PH_DONE;
				end
				default: nx.phase = st.phase;
			endcase
		end
		return nx;
	endfunction

endpackage

>>> sv/http_header_length_framer_unit.sv
// http header framer top level: input register, header scan, result register
// depends on hhlf_pkg
//
// Takes one connection byte or close event per item and returns one result per item:
// header end, message end, decoded content length and the bodyless and close flags.
// Throughput is one item per clock while the result side does not stall; each item moves
// through the input register and then the result register, with the scan state updated as
// it leaves the input register. A close event ends the message at any time; body bytes
// are counted in a COUNT_WIDTH-bit saturating counter against the held length.
module http_header_length_framer_unit #(
	parameter int COUNT_WIDTH = 32
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	input  logic [hhlf_pkg::IN_DATA_W-1:0]     s_tdata,  // data_byte
	input  logic [0:0]                         s_tuser,  // operation
	output logic                               m_tvalid,
	input  logic                               m_tready,
	// header_end, body_length[30:0], length_known, bodyless, connection_closed, zero pad
	output logic [hhlf_pkg::OUT_DATA_W-1:0]    m_tdata,
	output logic                               m_tlast   // message_end
);
	import hhlf_pkg::*;

	localparam int CMP_W = (COUNT_WIDTH > LEN_W) ? COUNT_WIDTH : LEN_W;

	// input register
	logic       valid_s1;
	logic       op_s1;
	logic [7:0] byte_s1;

	// scan state
	logic                   in_body_q;
	logic                   cr_pending_q;
	logic                   first_line_q;
	hdr_st_t                hdr_q;
	logic                   known_q;
	logic [LEN_W-1:0]       held_q;
	logic [COUNT_WIDTH-1:0] count_q;

	// next values
	logic                   adv;
	logic                   done;
	logic                   hdr_end;
	logic                   sep;
	logic                   in_body_nx;
	logic                   cr_pending_nx;
	logic                   first_line_nx;
	hdr_st_t                hdr_nx;
	logic                   known_nx;
	logic [LEN_W-1:0]       held_nx;
	logic [COUNT_WIDTH-1:0] count_nx;
	logic                   bl_out;
	logic [LEN_W-1:0]       len_out;
	logic [OUT_DATA_W-1:0]  res_word;

	// handshake: the input register moves on whenever the result register is free
	assign adv      = valid_s1 && (!m_tvalid || m_tready);
	assign s_tready = !valid_s1 || adv;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			op_s1   <= s_tuser[0];
			byte_s1 <= s_tdata;
		end
	end

	// per-item scan step
	always_comb begin
		done          = 1'b0;
		hdr_end       = 1'b0;
		sep           = 1'b0;
		in_body_nx    = in_body_q;
		cr_pending_nx = cr_pending_q;
		first_line_nx = first_line_q;
		hdr_nx        = hdr_q;
		known_nx      = known_q;
		held_nx       = held_q;
		count_nx      = count_q;
		if (op_s1 == OP_CLOSE) begin
			done = 1'b1;
		end else if (in_body_q) begin
			if (count_q != {COUNT_WIDTH{1'b1}})
				count_nx = count_q + 1'b1;
			if (known_q && (CMP_W'(count_nx) >= CMP_W'(held_q)))
				done = 1'b1;
		end else begin
			// held cr: either half of a crlf or an ordinary byte
			if (cr_pending_q) begin
				cr_pending_nx = 1'b0;
				if (byte_s1 == CH_LF)
					sep = 1'b1;
				else
					hdr_nx = content_byte(hdr_nx, first_line_q, CH_CR);
			end
			if (!sep) begin
				if (byte_s1 == CH_LF)
					sep = 1'b1;
				else if (byte_s1 == CH_CR)
					cr_pending_nx = 1'b1;
				else
					hdr_nx = content_byte(hdr_nx, first_line_q, byte_s1);
			end
			// line end or header end
			if (sep) begin
				if (hdr_q.line_empty) begin
					hdr_end    = 1'b1;
					in_body_nx = 1'b1;
					if (hdr_q.bodyless || (known_q && (held_q == '0)))
						done = 1'b1;
				end else begin
					if (hdr_q.name_alive && hdr_q.colon) begin
						held_nx = hdr_q.neg ? '0 : hdr_q.acc;
						known_nx = !(hdr_q.neg && (hdr_q.acc == LEN_W'(1)));
					end
					first_line_nx = 1'b0;
					hdr_nx        = line_restart(hdr_q);
				end
			end
		end
	end

	// result fields
	always_comb begin
		bl_out                      = hdr_nx.bodyless;
		len_out                     = (bl_out || !known_nx) ? '0 : held_nx;
		res_word                    = '0;
		res_word[O_HDR_END]         = hdr_end;
		res_word[O_LEN_HI:O_LEN_LO] = len_out;
		res_word[O_KNOWN]           = bl_out || known_nx;
		res_word[O_BLESS]           = bl_out;
		res_word[O_CLOSED]          = (op_s1 == OP_CLOSE);
	end

	// scan state update, back to idle at message end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_body_q    <= 1'b0;
			cr_pending_q <= 1'b0;
			first_line_q <= 1'b1;
			hdr_q        <= line_restart('0);
			known_q      <= 1'b0;
			held_q       <= '0;
			count_q      <= '0;
		end else if (adv) begin
			if (done) begin
				in_body_q    <= 1'b0;
				cr_pending_q <= 1'b0;
				first_line_q <= 1'b1;
				hdr_q        <= line_restart('0);
				known_q      <= 1'b0;
				held_q       <= '0;
				count_q      <= '0;
			end else begin
				in_body_q    <= in_body_nx;
				cr_pending_q <= cr_pending_nx;
				first_line_q <= first_line_nx;
				hdr_q        <= hdr_nx;
				known_q      <= known_nx;
				held_q       <= held_nx;
				count_q      <= count_nx;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (!m_tvalid || m_tready) begin
			m_tvalid <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			m_tlast <= done;
			m_tdata <= res_word;
		end
	end

endmodule

>>> sv/hhlf_checker.sv
// port-level checks on the framer result stream, bound to the top level
// depends on hhlf_pkg and http_header_length_framer_unit_macros.svh
`include "http_header_length_framer_unit_macros.svh"

module hhlf_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            m_tvalid,
	input logic                            m_tready,
	input logic [hhlf_pkg::OUT_DATA_W-1:0] m_tdata,
	input logic                            m_tlast
);
	import hhlf_pkg::*;

	// a stalled result item holds
	`HHLF_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast), "result item changed while stalled")

	// a close always ends the message
	`HHLF_ASSERT_NOW(a_close_ends, m_tvalid && m_tdata[O_CLOSED], m_tlast, "close without message end")

	// a bodyless message ends at its header end
	`HHLF_ASSERT_NOW(a_bodyless_end, m_tvalid && m_tdata[O_HDR_END] && m_tdata[O_BLESS], m_tlast, "bodyless header end did not end message")

	// a nonzero length only with a known length and a body
	`HHLF_ASSERT_NOW(a_len_known, m_tvalid && (m_tdata[O_LEN_HI:O_LEN_LO] != '0), m_tdata[O_KNOWN] && !m_tdata[O_BLESS], "length reported while unknown or bodyless")

endmodule

bind http_header_length_framer_unit hhlf_checker u_hhlf_checker (.*);

>>> test/http_header_length_framer_unit_tb.sv
// self-checking testbench for the http header length framer
// drives connection byte streams and close events, predicts every result item
// depends on hhlf_pkg and http_header_length_framer_unit
module http_header_length_framer_unit_tb;
	import hhlf_pkg::*;

	localparam int COUNT_W     = 32;
	localparam int RAND_ITEMS  = 2000;
	localparam int STALL_LIMIT = 5000;
	localparam int DRAIN_LIMIT = 1000;

	typedef struct {
		logic       op;
		logic [7:0] b;
		bit         hold;
	} conn_item_t;

	typedef struct packed {
		logic             msg_end;
		logic             hdr_end;
		logic [LEN_W-1:0] length;
		logic             known;
		logic             bodyless;
		logic             closed;
	} framing_t;

	logic                  clk      = 1'b0;
	logic                  arst_n   = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata  = '0;
	logic [0:0]            s_tuser  = '0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic                  m_tlast;

	conn_item_t conn_bytes [$];
	framing_t   framings_due [$];
	bit         pause_next;
	int         total_n;
	int         sent_n;
	int         returned_n;
	int         stall_n;
	int         fail_n;

	// predicted framer state
	logic                    in_body, cr_pend, line_blank, first_line;
	logic [3:0]              pfx_pos, nm_pos;
	logic [2:0]              pfx_live;
	logic                    nm_live, nm_colon;
	val_phase_t              val_phase;
	logic                    val_neg;
	logic [LEN_W-1:0]        val_acc, len_held;
	logic                    len_known, msg_bodyless;
	logic [COUNT_W-1:0]      body_cnt;

	string pfx_txt [3] = '{"GET", "HTTP/1.1 401", "HTTP/1.0 401"};
	string cl_name     = "content-length";

	http_header_length_framer_unit #(
		.COUNT_WIDTH(COUNT_W)
	) dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),   // data_byte
		.s_tuser (s_tuser),   // operation
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		// header_end, body_length[30:0], length_known, bodyless, connection_closed, pad
		.m_tdata (m_tdata),
		.m_tlast (m_tlast)    // message_end
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// space, tab, lf, vt, ff and cr
	function automatic logic blank_byte(input logic [7:0] c);
		return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
	endfunction

	// per-line scan state back to line start
	function automatic void restart_line();
		line_blank = 1'b1;
		pfx_pos    = '0;
		pfx_live   = 3'b111;
		nm_pos     = '0;
		nm_live    = 1'b1;
		nm_colon   = 1'b0;
		val_phase  = PH_SKIP;
		val_neg    = 1'b0;
		val_acc    = '0;
	endfunction

	function automatic void restart_msg();
		in_body      = 1'b0;
		cr_pend      = 1'b0;
		first_line   = 1'b1;
		restart_line();
		len_held     = '0;
		len_known    = 1'b0;
		msg_bodyless = 1'b0;
		body_cnt     = '0;
	endfunction

	// one ordinary header byte: prefix test, name match, value decode
	function automatic void scan_line_byte(input logic [7:0] c);
		logic [7:0] lc;
		logic [3:0] p;
		logic       dig;
		logic [34:0] prod;
		string      s;
		line_blank = 1'b0;
		dig        = (c >= CH_ZERO) && (c <= CH_NINE);
		if (first_line) begin
			p = pfx_pos;
			for (int i = 0; i < 3; i++) begin
				s = pfx_txt[i];
				if (pfx_live[i]) begin
					if (p < s.len()) begin
						if (c != s[p])
							pfx_live[i] = 1'b0;
					end else begin
						if (blank_byte(c))
							msg_bodyless = 1'b1;
						pfx_live[i] = 1'b0;
					end
				end
			end
			pfx_pos = (p < 4'd13) ? p + 4'd1 : 4'd13;
		end
		if (!nm_colon) begin
			if (c == CH_COLON) begin
				nm_live  = nm_live && (nm_pos == 4'd14);
				nm_colon = 1'b1;
			end else begin
				lc = (c >= CH_UP_A && c <= CH_UP_Z) ? c + 8'd32 : c;
				if (!(nm_pos < 4'd14 && lc == cl_name[nm_pos]))
					nm_live = 1'b0;
				nm_pos = (nm_pos < 4'd15) ? nm_pos + 4'd1 : 4'd15;
			end
		end else begin
			case (val_phase)
				PH_SKIP: begin
					if (blank_byte(c)) begin
						val_phase = PH_SKIP;
					end else if (c == CH_PLUS) begin
						val_phase = PH_DIGITS;
					end else if (c == CH_MINUS) begin
						val_phase = PH_DIGITS;
						val_neg   = 1'b1;
					end else if (dig) begin
						val_phase = PH_DIGITS;
						val_acc   = LEN_W'(c - CH_ZERO);
					end else begin
						val_phase = PH_DONE;
					end
				end
				PH_DIGITS: begin
					if (dig) begin
						prod    = 35'(val_acc) * 35'd10 + 35'(c - CH_ZERO);
						val_acc = (prod > 35'(LEN_MAX)) ? LEN_MAX : prod[LEN_W-1:0];
					end else begin
						val_phase = PH_DONE;
					end
				end
				default: val_phase = val_phase;
			endcase
		end
	endfunction

	// end of a non-empty header line; a matched length line updates the held length
	function automatic void close_line();
		if (nm_live && nm_colon) begin
			len_held = '0;
			if (!val_neg) begin
				len_known = 1'b1;
				len_held  = val_acc;
			end else if (val_acc == 1) begin
				// minus one: length absent again
				len_known = 1'b0;
			end else begin
				len_known = 1'b1;
			end
		end
		first_line = 1'b0;
		restart_line();
	endfunction

	// framing result for one accepted item, advancing the predicted state
	function automatic framing_t next_framing(input logic op, input logic [7:0] c);
		framing_t r;
		logic     sep;
		r   = '0;
		sep = 1'b0;
		if (op == OP_CLOSE) begin
			r.msg_end = 1'b1;
		end else if (in_body) begin
			if (body_cnt != '1)
				body_cnt = body_cnt + 1'b1;
			if (len_known && body_cnt >= len_held)
				r.msg_end = 1'b1;
		end else begin
			// a cr only counts as a line break when an lf follows
			if (cr_pend) begin
				cr_pend = 1'b0;
				if (c == CH_LF)
					sep = 1'b1;
				else
					scan_line_byte(CH_CR);
			end
			if (!sep) begin
				if (c == CH_LF)
					sep = 1'b1;
				else if (c == CH_CR)
					cr_pend = 1'b1;
				else
					scan_line_byte(c);
			end
			if (sep) begin
				if (line_blank) begin
					r.hdr_end = 1'b1;
					in_body   = 1'b1;
					if (msg_bodyless || (len_known && len_held == 0))
						r.msg_end = 1'b1;
				end else begin
					close_line();
				end
			end
		end
		r.bodyless = msg_bodyless;
		r.known    = msg_bodyless || len_known;
		r.length   = (msg_bodyless || !len_known) ? '0 : len_held;
		r.closed   = op;
		if (r.msg_end)
			restart_msg();
		return r;
	endfunction

	task automatic flag_mismatch(input string what, input longint unsigned got,
		input longint unsigned want);
		$display("mismatch %s at result %0d: got %0h, want %0h", what, returned_n, got, want);
		fail_n++;
	endtask

	// stimulus queue helpers
	task automatic add_item(input logic op, input logic [7:0] b);
		conn_item_t it;
		it.op      = op;
		it.b       = b;
		it.hold    = pause_next;
		pause_next = 1'b0;
		conn_bytes.push_back(it);
	endtask

	task automatic add_byte(input logic [7:0] b);
		add_item(OP_DATA, b);
	endtask

	task automatic add_close();
		add_item(OP_CLOSE, 8'($urandom_range(255)));
	endtask

	task automatic add_text(input string s);
		for (int i = 0; i < s.len(); i++)
			add_byte(s[i]);
	endtask

	task automatic add_eol();
		if ($urandom_range(9) < 7)
			add_byte(CH_CR);
		add_byte(CH_LF);
	endtask

	function automatic logic [7:0] line_junk();
		logic [7:0] v;
		v = 8'($urandom_range(255));
		while (v == CH_LF)
			v = 8'($urandom_range(255));
		return v;
	endfunction

	// content-length with each letter in random case
	task automatic add_cl_name();
		logic [7:0] ch;
		for (int i = 0; i < cl_name.len(); i++) begin
			ch = cl_name[i];
			if (ch >= "a" && ch <= "z" && $urandom_range(1))
				ch = ch - 8'd32;
			add_byte(ch);
		end
	endtask

	// one header block with random content, then the body it calls for
	task automatic add_message();
		int sel, v, want;
		bit big, bless;
		want  = -1;
		big   = 0;
		bless = 0;
		if ($urandom_range(49) == 0)
			pause_next = 1'b1;
		sel = $urandom_range(10);
		case (sel)
			0: begin add_text("GET /index.html HTTP/1.1"); bless = 1; end
			1: begin add_text("HTTP/1.1 401 Unauthorized"); bless = 1; end
			2: begin add_text("HTTP/1.0 401\tDenied"); bless = 1; end
			3: add_text("HTTP/1.1 200 OK");
			4: add_text("POST /form HTTP/1.1");
			5: add_text("GET");
			6: add_text("get / HTTP/1.1");
			7: begin add_text("GET"); add_byte(CH_CR); add_text("/x"); bless = 1; end
			8: add_text("HTTP/1.0 4010 X");
			9: ;
			default: repeat ($urandom_range(1, 16)) add_byte(line_junk());
		endcase
		if (sel != 9) begin
			add_eol();
			if ($urandom_range(19) == 0) begin
				add_close();
				return;
			end
			repeat ($urandom_range(0, 4)) begin
				v = $urandom_range(9);
				if (v < 5) begin
					add_cl_name();
					add_byte(CH_COLON);
					repeat ($urandom_range(0, 2))
						add_byte($urandom_range(1) ? CH_SPACE : CH_TAB);
					big = 0;
					case ($urandom_range(11))
						6: begin add_text("-1"); want = -1; end
						7: begin add_text($sformatf("-%0d", $urandom_range(0, 9))); want = 0; end
						8: begin want = $urandom_range(1, 24); add_text($sformatf("+%0d", want)); end
						9: begin
							big = 1;
							case ($urandom_range(3))
								0: add_text("2147483647");
								1: add_text("2147483648");
								2: add_text("99999999999999");
								default: add_text("40000");
							endcase
						end
						10: begin if ($urandom_range(1)) add_text("abc"); want = 0; end
						11: begin want = $urandom_range(1, 24); add_text($sformatf("%0dx3 ", want)); end
						default: begin
							want = $urandom_range(0, 24);
							add_text($sformatf("%0d", want));
						end
					endcase
				end else if (v < 7) begin
					case ($urandom_range(2))
						0: add_text("Content-Lengthx: 3");
						1: add_text("content-lengt: 3");
						default: add_text("content-length : 3");
					endcase
				end else if (v == 7) begin
					add_text("Host: example");
				end else begin
					repeat ($urandom_range(1, 20)) add_byte(line_junk());
				end
				add_eol();
				if ($urandom_range(19) == 0) begin
					add_close();
					return;
				end
			end
		end
		// empty line closes the headers
		add_eol();
		if (bless || (!big && want == 0))
			return;
		if (big || want < 0 || $urandom_range(9) == 0) begin
			repeat ($urandom_range(0, 6)) add_byte(8'($urandom_range(255)));
			add_close();
		end else begin
			repeat (want) add_byte(8'($urandom_range(255)));
		end
	endtask

	// input side: presents queued items, idling and pausing as the phase asks
	always @(posedge clk or negedge arst_n) begin
		conn_item_t nxt;
		int         pct;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata  <= '0;
			s_tuser  <= '0;
		end else begin
			if (s_tvalid && s_tready)
				sent_n++;
			if (!s_tvalid || s_tready) begin
				pct = (sent_n * 3 < total_n) ? 37 : (sent_n * 3 < 2 * total_n) ? 66 : 0;
				if (conn_bytes.size() != 0 && !(conn_bytes[0].hold && returned_n != sent_n)
					&& $urandom_range(99) >= pct) begin
					nxt      = conn_bytes.pop_front();
					s_tvalid <= 1'b1;
					s_tdata  <= nxt.b;
					s_tuser  <= nxt.op;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// output side: predicts on input handshakes, checks result items, watchdog
	always @(posedge clk or negedge arst_n) begin
		framing_t want;
		int       pct;
		if (!arst_n) begin
			m_tready   <= 1'b0;
			returned_n <= 0;
			stall_n    <= 0;
			restart_msg();
		end else begin
			if (s_tvalid && s_tready)
				framings_due.push_back(next_framing(s_tuser[0], s_tdata));
			if (m_tvalid && m_tready) begin
				if (framings_due.size() == 0) begin
					flag_mismatch("result with none pending", 1, 0);
				end else begin
					want = framings_due.pop_front();
					if (m_tlast !== want.msg_end)
						flag_mismatch("message_end", m_tlast, want.msg_end);
					if (m_tdata[O_HDR_END] !== want.hdr_end)
						flag_mismatch("header_end", m_tdata[O_HDR_END], want.hdr_end);
					if (m_tdata[O_LEN_HI:O_LEN_LO] !== want.length)
						flag_mismatch("body_length", m_tdata[O_LEN_HI:O_LEN_LO], want.length);
					if (m_tdata[O_KNOWN] !== want.known)
						flag_mismatch("length_known", m_tdata[O_KNOWN], want.known);
					if (m_tdata[O_BLESS] !== want.bodyless)
						flag_mismatch("bodyless", m_tdata[O_BLESS], want.bodyless);
					if (m_tdata[O_CLOSED] !== want.closed)
						flag_mismatch("connection_closed", m_tdata[O_CLOSED], want.closed);
				end
				returned_n <= returned_n + 1;
			end
			pct = (returned_n * 3 < total_n) ? 66 : (returned_n * 3 < 2 * total_n) ? 37 : 0;
			m_tready <= ($urandom_range(99) >= pct);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
				stall_n <= 0;
			end else if (stall_n < STALL_LIMIT) begin
				stall_n <= stall_n + 1;
			end else begin
				$display("CHECK FAILED");
				$finish;
			end
		end
	end

	initial begin
		int wait_n;
		// short opening sequence: close on an idle link, odd bytes, bodyless get,
		// bare cr in a line, empty line with no length then close
		add_close();
		add_byte(8'h00);
		add_byte(8'hFF);
		add_close();
		add_text("GET ");
		add_byte(CH_LF);
		add_byte(CH_LF);
		pause_next = 1'b1;
		add_byte(CH_CR);
		add_byte(CH_CR);
		add_byte(CH_LF);
		add_byte(CH_LF);
		add_byte(8'h7F);
		add_close();
		wait_n = conn_bytes.size();
		while (conn_bytes.size() < wait_n + RAND_ITEMS) begin
			if ($urandom_range(99) < 8) begin
				repeat ($urandom_range(1, 8))
					add_item(($urandom_range(99) < 15) ? OP_CLOSE : OP_DATA,
						8'($urandom_range(255)));
			end else begin
				add_message();
			end
		end
		total_n = conn_bytes.size();

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// drain the stimulus, then the outstanding results
		while (conn_bytes.size() != 0 || s_tvalid)
			@(negedge clk);
		wait_n = 0;
		while (framings_due.size() != 0 && wait_n < DRAIN_LIMIT) begin
			@(negedge clk);
			wait_n++;
		end
		repeat (8) @(negedge clk);
		if (framings_due.size() != 0)
			flag_mismatch("results outstanding", framings_due.size(), 0);
		if (fail_n == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

>>> sim.f
+incdir+sv
sv/hhlf_pkg.sv
sv/http_header_length_framer_unit.sv
sv/hhlf_checker.sv
test/http_header_length_framer_unit_tb.sv
